/* sv/grcast_pkg.sv */
package grcast_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int POS_W     = 21;
  localparam int VEC_W     = 18;
  localparam int SCR_W     = 11;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 3;
  localparam int COL_W     = 10;
  localparam int CODE_W    = 3;
  localparam int TIDX_W    = 4;
  localparam int TEXC_W    = 8;
  localparam int ROW_W     = 10;
  localparam int ROW_MAX   = 1023;

  // tile store geometry
  localparam int MAP_SIZE  = 32;
  localparam int MAP_AW    = $clog2(MAP_SIZE);
  localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int MEM_AW    = 2 * MAP_AW;
  localparam int MC_W      = MAP_AW + 2;

  // datapath widths
  localparam int CAM_W   = 28;
  localparam int RAY_W   = 30;
  localparam int AX_W    = RAY_W - 1;
  localparam int NUM_W   = MC_W + FRAC_BITS;
  localparam int PROD_W  = NUM_W + RAY_W;
  localparam int SAT_W   = 48;
  localparam int SD_W    = 56;
  localparam int LH_W    = 14;
  localparam int LH_MAX  = 8192;

  // divider sizing and bit counts per division
  localparam int DV_NUM_W = PROD_W - 1;
  localparam int DV_DEN_W = SAT_W;
  localparam int DV_CNT_W = $clog2(DV_NUM_W + 1);
  localparam int N_CAM    = COL_W + 1 + FRAC_BITS;
  localparam int N_SIDE   = 2 * FRAC_BITS + 1;
  localparam int N_PERP   = NUM_W - 1 + FRAC_BITS;
  localparam int N_LH     = SCR_W + FRAC_BITS;
  localparam int N_WALL   = DV_NUM_W;

  // register reset values
  localparam logic [POS_W-1:0]        POS_X_RST   = 21'd1441792;
  localparam logic [POS_W-1:0]        POS_Y_RST   = 21'd622592;
  localparam logic signed [VEC_W-1:0] DIR_X_RST   = -18'sd65536;
  localparam logic signed [VEC_W-1:0] DIR_Y_RST   = 18'sd0;
  localparam logic signed [VEC_W-1:0] PLANE_X_RST = 18'sd0;
  localparam logic signed [VEC_W-1:0] PLANE_Y_RST = 18'sd32768;
  localparam logic [SCR_W-1:0]        SCR_RST     = 11'd800;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X, REG_POS_Y, REG_DIR_X, REG_DIR_Y,
    REG_PLANE_X, REG_PLANE_Y, REG_SCR_W, REG_SCR_H
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_MUL_X, ST_MUL_Y,
    ST_RAY_Y, ST_STEP, ST_TEST, ST_NUM, ST_MUL_W, ST_FIN
  } rc_state_t;

  typedef enum logic [2:0] {
    OP_CAM, OP_SDX, OP_SDY, OP_DDX, OP_DDY, OP_PERP, OP_LH, OP_WALL
  } div_op_t;

  typedef struct packed {
    logic                start;
    logic [DV_CNT_W-1:0] nbits;
  } dv_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dv_sts_t;

endpackage

/* sv/grcast_if.sv */
interface grcast_in_if import grcast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [MAP_AW-1:0] tile_x;
  logic [MAP_AW-1:0] tile_y;
  logic [CODE_W-1:0] tile_code;
  logic [COL_W-1:0]  column;

  modport source(output valid, req_type, tile_x, tile_y, tile_code, column, input ready);
  modport sink(input valid, req_type, tile_x, tile_y, tile_code, column, output ready);
endinterface

interface grcast_out_if import grcast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  out_column;
  logic [ROW_W-1:0]  draw_start;
  logic [ROW_W-1:0]  draw_end;
  logic [TIDX_W-1:0] tile_index;
  logic [TEXC_W-1:0] tex_column;
  logic              no_hit;

  modport source(output valid, out_column, draw_start, draw_end, tile_index, tex_column,
                 no_hit, input ready);
  modport sink(input valid, out_column, draw_start, draw_end, tile_index, tex_column,
               no_hit, output ready);
endinterface

/* sv/grcast_ram.sv */
module grcast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/grcast_div.sv */
module grcast_div import grcast_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dv_ctl_t             ctl,
  input  logic [DV_NUM_W-1:0] num,
  input  logic [DV_DEN_W-1:0] den,
  output dv_sts_t             sts,
  output logic [DV_NUM_W-1:0] quo,
  output logic [DV_DEN_W-1:0] rem
);

  logic                busy;
  logic                done;
  logic [DV_CNT_W-1:0] idx;
  logic [DV_NUM_W-1:0] num_r;
  logic [DV_DEN_W-1:0] den_r;
  logic [DV_DEN_W:0]   trial;
  logic                fits;

  // one restoring step per cycle, msb first
  assign trial = {rem, num_r[idx]};
  assign fits  = trial >= {1'b0, den_r};

  assign sts.busy = busy;
  assign sts.done = done;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && idx == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num_r <= num;
      den_r <= den;
      idx   <= ctl.nbits - DV_CNT_W'(1);
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      if (fits) begin
        rem      <= DV_DEN_W'(trial - {1'b0, den_r});
        quo[idx] <= 1'b1;
      end else begin
        rem <= trial[DV_DEN_W-1:0];
      end
      idx <= idx - DV_CNT_W'(1);
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("divider done without a run");

  a_nbits_range: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> (ctl.nbits != '0 && ctl.nbits <= DV_CNT_W'(DV_NUM_W)))
    else $error("divider bit count out of range");

endmodule

/* sv/grid_raycast_wall_column_unit.sv */
// tile write: taken in the idle state, no result
// column cast: up to MAX_STEPS grid steps, with further divisions on a wall hit, all on
// the shared bit-serial divider forming quotients a bit a cycle
// one request in flight at a time; a finished result waits in the output register
// reset: configuration registers take their defaults and the tile store is cleared entry
// by entry; no request is taken while it is being cleared
module grid_raycast_wall_column_unit import grcast_pkg::*; #(
  parameter int TEX_SIZE  = 256,
  parameter int MAX_STEPS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  grcast_in_if.sink            in_ch,
  grcast_out_if.source         out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int TW     = $clog2(TEX_SIZE) + 1;

  // configuration registers
  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [SCR_W-1:0]        scr_w, scr_h;

  // control
  rc_state_t         state, state_next;
  div_op_t           op;
  logic              out_valid;
  logic [MEM_AW-1:0] clr_cnt;

  // datapath
  logic [COL_W-1:0]         col;
  logic signed [CAM_W-1:0]  cam;
  logic signed [PROD_W-1:0] prod;
  logic signed [RAY_W-1:0]  rdx, rdy;
  logic [SD_W-1:0]          sdx, sdy, ddx, ddy;
  logic signed [MC_W-1:0]   mx, my;
  logic [STEP_W-1:0]        steps;
  logic                     side;
  logic                     hit;
  logic [CODE_W-1:0]        code;
  logic signed [NUM_W-1:0]  num_r;
  logic [SAT_W-1:0]         perp;
  logic [LH_W-1:0]          lh;
  logic [FRAC_BITS-1:0]     wall_frac;

  // shared units
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr, ram_raddr;
  logic [CODE_W-1:0] ram_wdata, ram_rdata;
  dv_ctl_t           dv_ctl;
  dv_sts_t           dv_sts;
  logic [DV_NUM_W-1:0] dv_num, dv_quo;
  logic [DV_DEN_W-1:0] dv_den, dv_rem;

  // derived values
  logic                     in_acc;
  logic [SCR_W-1:0]         w_eff, h_eff;
  logic [AX_W-1:0]          ax, ay;
  logic                     neg_x, neg_y;
  logic [FRAC_BITS:0]       dist_x, dist_y;
  logic                     take_x;
  logic signed [MC_W-1:0]   mx_n, my_n;
  logic                     off_map;
  logic signed [MC_W-1:0]   bnd_cell;
  logic signed [NUM_W-1:0]  num_calc;
  logic [NUM_W-2:0]         num_mag;
  logic [DV_NUM_W-1:0]      prod_mag;
  logic [AX_W-1:0]          a_side;
  logic                     den_zero;
  logic signed [NUM_W-1:0]  mul_a;
  logic signed [RAY_W-1:0]  mul_b;
  logic [FRAC_BITS-1:0]     fq;
  logic [FRAC_BITS-1:0]     pos_other_frac;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign w_eff  = (scr_w == '0) ? SCR_W'(1) : scr_w;
  assign h_eff  = (scr_h == '0) ? SCR_W'(1) : scr_h;
  assign neg_x  = rdx[RAY_W-1];
  assign neg_y  = rdy[RAY_W-1];
  assign ax     = neg_x ? AX_W'(-rdx) : AX_W'(rdx);
  assign ay     = neg_y ? AX_W'(-rdy) : AX_W'(rdy);
  assign dist_x = neg_x ? {1'b0, pos_x[FRAC_BITS-1:0]}
                        : (FRAC_BITS+1)'(ONE) - {1'b0, pos_x[FRAC_BITS-1:0]};
  assign dist_y = neg_y ? {1'b0, pos_y[FRAC_BITS-1:0]}
                        : (FRAC_BITS+1)'(ONE) - {1'b0, pos_y[FRAC_BITS-1:0]};

  // grid step: ties go to y
  assign take_x  = sdx < sdy;
  assign mx_n    = !take_x ? mx : (neg_x ? mx - MC_W'(1) : mx + MC_W'(1));
  assign my_n    = take_x ? my : (neg_y ? my - MC_W'(1) : my + MC_W'(1));
  assign off_map = mx_n < 0 || my_n < 0 || mx_n >= MC_W'(MAP_SIZE) ||
                   my_n >= MC_W'(MAP_SIZE);

  // distance from viewer to the crossed grid line
  assign bnd_cell = side ? (neg_y ? my + MC_W'(1) : my) : (neg_x ? mx + MC_W'(1) : mx);
  assign num_calc = $signed({bnd_cell, {FRAC_BITS{1'b0}}})
                  - $signed(NUM_W'(side ? pos_y : pos_x));
  assign num_mag  = num_r[NUM_W-1] ? (NUM_W-1)'(-num_r) : (NUM_W-1)'(num_r);
  assign prod_mag = prod[PROD_W-1] ? DV_NUM_W'(-prod) : DV_NUM_W'(prod);
  assign a_side   = side ? ay : ax;

  // multiplier operands
  always_comb begin
    mul_a = $signed(NUM_W'(plane_x));
    mul_b = $signed(RAY_W'(cam));
    unique case (state)
      ST_MUL_Y: mul_a = $signed(NUM_W'(plane_y));
      ST_MUL_W: begin
        mul_a = num_r;
        mul_b = side ? rdx : rdy;
      end
      default: mul_a = $signed(NUM_W'(plane_x));
    endcase
  end

  // divider operands by operation
  always_comb begin
    dv_num       = '0;
    dv_den       = '0;
    dv_ctl.start = state == ST_DIV_GO;
    dv_ctl.nbits = DV_CNT_W'(N_SIDE);
    unique case (op)
      OP_CAM: begin
        dv_num       = DV_NUM_W'({col, {(FRAC_BITS+1){1'b0}}});
        dv_den       = DV_DEN_W'(w_eff);
        dv_ctl.nbits = DV_CNT_W'(N_CAM);
      end
      OP_SDX: begin
        dv_num = DV_NUM_W'({dist_x, {FRAC_BITS{1'b0}}});
        dv_den = DV_DEN_W'(ax);
      end
      OP_SDY: begin
        dv_num = DV_NUM_W'({dist_y, {FRAC_BITS{1'b0}}});
        dv_den = DV_DEN_W'(ay);
      end
      OP_DDX: begin
        dv_num = DV_NUM_W'(1) << (2 * FRAC_BITS);
        dv_den = DV_DEN_W'(ax);
      end
      OP_DDY: begin
        dv_num = DV_NUM_W'(1) << (2 * FRAC_BITS);
        dv_den = DV_DEN_W'(ay);
      end
      OP_PERP: begin
        dv_num       = DV_NUM_W'({num_mag, {FRAC_BITS{1'b0}}});
        dv_den       = DV_DEN_W'(a_side);
        dv_ctl.nbits = DV_CNT_W'(N_PERP);
      end
      OP_LH: begin
        dv_num       = DV_NUM_W'({h_eff, {FRAC_BITS{1'b0}}});
        dv_den       = perp;
        dv_ctl.nbits = DV_CNT_W'(N_LH);
      end
      OP_WALL: begin
        dv_num       = prod_mag;
        dv_den       = DV_DEN_W'(a_side);
        dv_ctl.nbits = DV_CNT_W'(N_WALL);
      end
      default: dv_num = '0;
    endcase
  end

  assign den_zero = dv_den == '0;

  // floored quotient, low fraction bits only
  always_comb begin
    if (prod[PROD_W-1] ^ (side ? neg_y : neg_x)) begin
      fq = FRAC_BITS'(-(dv_quo[FRAC_BITS-1:0] + FRAC_BITS'(dv_rem != '0)));
    end else begin
      fq = dv_quo[FRAC_BITS-1:0];
    end
    pos_other_frac = side ? pos_x[FRAC_BITS-1:0] : pos_y[FRAC_BITS-1:0];
  end

  grcast_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (dv_ctl),
    .num (dv_num),
    .den (dv_den),
    .sts (dv_sts),
    .quo (dv_quo),
    .rem (dv_rem)
  );

  grcast_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= POS_X_RST;
      pos_y   <= POS_Y_RST;
      dir_x   <= DIR_X_RST;
      dir_y   <= DIR_Y_RST;
      plane_x <= PLANE_X_RST;
      plane_y <= PLANE_Y_RST;
      scr_w   <= SCR_RST;
      scr_h   <= SCR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POS_X:   pos_x   <= cfg_data[POS_W-1:0];
        REG_POS_Y:   pos_y   <= cfg_data[POS_W-1:0];
        REG_DIR_X:   dir_x   <= $signed(cfg_data[VEC_W-1:0]);
        REG_DIR_Y:   dir_y   <= $signed(cfg_data[VEC_W-1:0]);
        REG_PLANE_X: plane_x <= $signed(cfg_data[VEC_W-1:0]);
        REG_PLANE_Y: plane_y <= $signed(cfg_data[VEC_W-1:0]);
        REG_SCR_W:   scr_w   <= cfg_data[SCR_W-1:0];
        REG_SCR_H:   scr_h   <= cfg_data[SCR_W-1:0];
        default:     scr_h   <= scr_h;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_cnt == MEM_AW'(MAP_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (in_acc && in_ch.req_type == REQ_CAST) state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (dv_sts.done) begin
          unique case (op)
            OP_CAM:  state_next = ST_MUL_X;
            OP_DDY:  state_next = ST_STEP;
            OP_LH:   state_next = ST_MUL_W;
            OP_WALL: state_next = ST_FIN;
            default: state_next = ST_DIV_GO;
          endcase
        end
      end
      ST_MUL_X:    state_next = ST_MUL_Y;
      ST_MUL_Y:    state_next = ST_RAY_Y;
      ST_RAY_Y:    state_next = ST_DIV_GO;
      ST_STEP:     state_next = off_map ? ST_FIN : ST_TEST;
      ST_TEST: begin
        priority if (ram_rdata != '0) state_next = ST_NUM;
        else if (steps == STEP_W'(MAX_STEPS)) state_next = ST_FIN;
        else state_next = ST_STEP;
      end
      ST_NUM:      state_next = ST_DIV_GO;
      ST_MUL_W:    state_next = ST_DIV_GO;
      ST_FIN:      if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready  = state == ST_IDLE;
    ram_we       = 1'b0;
    ram_waddr    = {in_ch.tile_y, in_ch.tile_x};
    ram_wdata    = in_ch.tile_code;
    ram_raddr    = {my_n[MAP_AW-1:0], mx_n[MAP_AW-1:0]};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_IDLE: ram_we = in_acc && in_ch.req_type == REQ_WRITE;
      default: ram_we = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + MEM_AW'(1);
      if (state == ST_FIN && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          col   <= in_ch.column;
          steps <= '0;
          hit   <= 1'b0;
          op    <= OP_CAM;
        end
      end
      ST_DIV_WAIT: begin
        if (dv_sts.done) begin
          unique case (op)
            OP_CAM: cam <= $signed(dv_quo[CAM_W-1:0]) - CAM_W'(ONE);
            OP_SDX: begin
              sdx <= den_zero ? SD_W'({SAT_W{1'b1}}) : SD_W'(dv_quo);
              op  <= OP_SDY;
            end
            OP_SDY: begin
              sdy <= den_zero ? SD_W'({SAT_W{1'b1}}) : SD_W'(dv_quo);
              op  <= OP_DDX;
            end
            OP_DDX: begin
              ddx <= den_zero ? SD_W'({SAT_W{1'b1}}) : SD_W'(dv_quo);
              op  <= OP_DDY;
            end
            OP_DDY: ddy <= den_zero ? SD_W'({SAT_W{1'b1}}) : SD_W'(dv_quo);
            OP_PERP: begin
              perp <= den_zero ? {SAT_W{1'b1}} : dv_quo[SAT_W-1:0];
              op   <= OP_LH;
            end
            OP_LH: begin
              if (perp == '0 || dv_quo > DV_NUM_W'(LH_MAX)) lh <= LH_W'(LH_MAX);
              else lh <= dv_quo[LH_W-1:0];
            end
            OP_WALL: wall_frac <= den_zero ? pos_other_frac : pos_other_frac + fq;
            default: op <= op;
          endcase
        end
      end
      ST_MUL_X: prod <= mul_a * mul_b;
      ST_MUL_Y: begin
        rdx  <= RAY_W'(dir_x) + $signed(prod[FRAC_BITS +: RAY_W]);
        prod <= mul_a * mul_b;
      end
      ST_RAY_Y: begin
        rdy <= RAY_W'(dir_y) + $signed(prod[FRAC_BITS +: RAY_W]);
        mx  <= $signed(MC_W'(pos_x[POS_W-1:FRAC_BITS]));
        my  <= $signed(MC_W'(pos_y[POS_W-1:FRAC_BITS]));
        op  <= OP_SDX;
      end
      ST_STEP: begin
        if (take_x) begin
          sdx  <= sdx + ddx;
          side <= 1'b0;
        end else begin
          sdy  <= sdy + ddy;
          side <= 1'b1;
        end
        mx    <= mx_n;
        my    <= my_n;
        steps <= steps + STEP_W'(1);
      end
      ST_TEST: begin
        if (ram_rdata != '0) begin
          code <= ram_rdata;
          hit  <= 1'b1;
        end
      end
      ST_NUM: begin
        num_r <= num_calc;
        op    <= OP_PERP;
      end
      ST_MUL_W: begin
        prod <= mul_a * mul_b;
        op   <= OP_WALL;
      end
      default: col <= col;
    endcase
  end

  // result forming
  logic [ROW_W-1:0]        h_half;
  logic [LH_W-2:0]         lh_half;
  logic signed [LH_W:0]    ds_s;
  logic [LH_W-1:0]         de_s;
  logic [ROW_W-1:0]        ds_v, de_v;
  logic [FRAC_BITS+TW-1:0] tex_prod;
  logic [TW-1:0]           tex_val, tex_fl;
  logic                    flip;
  logic [TIDX_W-1:0]       idx_base, idx_v;

  always_comb begin
    h_half  = h_eff[SCR_W-1:1];
    lh_half = lh[LH_W-1:1];
    ds_s    = $signed((LH_W+1)'(h_half)) - $signed((LH_W+1)'(lh_half));
    priority if (ds_s < 0) ds_v = '0;
    else if (ds_s > (LH_W+1)'(ROW_MAX)) ds_v = ROW_W'(ROW_MAX);
    else ds_v = ds_s[ROW_W-1:0];
    de_s = LH_W'(lh_half) + LH_W'(h_half);
    if (de_s >= LH_W'(h_eff)) de_s = LH_W'(h_eff) - LH_W'(1);
    de_v = (de_s > LH_W'(ROW_MAX)) ? ROW_W'(ROW_MAX) : de_s[ROW_W-1:0];

    tex_prod = (FRAC_BITS+TW)'(wall_frac) * (FRAC_BITS+TW)'(TEX_SIZE);
    tex_val  = tex_prod[FRAC_BITS +: TW];
    flip     = side ? neg_y : (!neg_x && rdx != '0);
    tex_fl   = flip ? TW'(TEX_SIZE - 1) - tex_val : tex_val;

    idx_base = (code >= CODE_W'(1) && code <= CODE_W'(4)) ? TIDX_W'(code) : TIDX_W'(5);
    idx_v    = side ? idx_base + TIDX_W'(5) : idx_base;
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!out_valid || out_ch.ready)) begin
      out_ch.out_column <= col;
      out_ch.no_hit     <= !hit;
      out_ch.draw_start <= hit ? ds_v : '0;
      out_ch.draw_end   <= hit ? de_v : '0;
      out_ch.tile_index <= hit ? idx_v : '0;
      out_ch.tex_column <= hit ? TEXC_W'(tex_fl) : '0;
    end
  end

  assign out_ch.valid = out_valid;

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    dv_sts.done |-> state == ST_DIV_WAIT)
    else $error("divider result outside wait state");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_TEST |-> (steps != '0 && steps <= STEP_W'(MAX_STEPS)))
    else $error("walk step count out of range");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside finish");

  a_step_follow: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP |=> (state == ST_TEST || state == ST_FIN))
    else $error("grid step not followed by test or finish");

  a_hit_has_code: assert property (@(posedge clk) disable iff (rst)
    state == ST_NUM |-> (hit && code != '0))
    else $error("distance stage without a wall hit");

endmodule
